[rtl/fraction_reducer_spf_defines.svh]
// ----------------------------------------------------------------------------
// Fraction reducer assertion macros
// Clocked implication checks shared by the fraction reducer RTL.
// ----------------------------------------------------------------------------
`ifndef FRACTION_REDUCER_SPF_DEFINES_SVH
`define FRACTION_REDUCER_SPF_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/frs_pkg.sv]
// ----------------------------------------------------------------------------
// Fraction reducer package
// Shared widths, command codes and the divider request type.
// ----------------------------------------------------------------------------
`default_nettype none

package frs_pkg;

  localparam int unsigned TABLE_SIZE = 65536;
  localparam int unsigned TABLE_AW   = $clog2(TABLE_SIZE);
  localparam int unsigned VAL_W      = 16;
  localparam int unsigned BAL_W      = 16;
  localparam int unsigned SIEVE_PMAX = 255;
  localparam int unsigned EXP_W      = 5;

  typedef enum logic [1:0] {
    CMD_ACC = 2'd0,
    CMD_RED = 2'd1,
    CMD_CLR = 2'd2,
    CMD_NOP = 2'd3
  } command_e;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] dividend;
    logic [VAL_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

[rtl/frs_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/frs_div.sv]
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module frs_div (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire frs_pkg::div_req_t       req_i,
  output      logic                    done_o,
  output      logic [frs_pkg::VAL_W-1:0] quot_o
);

  localparam int unsigned W  = frs_pkg::VAL_W;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [W:0]    rem_q;
  logic [W-1:0]  quo_q;
  logic [W-1:0]  dsr_q;
  logic [W:0]    rem_sh;
  logic          fits;

  assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
  assign fits   = rem_sh >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      quo_q <= {quo_q[W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

[rtl/fraction_reducer_spf.sv]
// ----------------------------------------------------------------------------
// Fraction reducer, smallest-prime-factor sieve
// Accumulates prime exponent balances and emits reduced factors.
// ----------------------------------------------------------------------------
// After reset the block fills a 65536-entry smallest-prime-factor RAM (one
// fill sweep, then marking multiples of 255 down to 2) and, in parallel,
// zeroes the 65536-entry balance RAM; in_stall_o is high until both finish.
// A clear beat reruns the zeroing sweep. Other beats are handled one at a
// time: each prime factor occurrence costs a table lookup plus a division by
// the radix-2 divider, and each distinct prime a second lookup and a balance
// read-modify-write plus, on a reduce beat, one multiply per kept exponent.
// A finished result sits in an output register and the next beat is taken
// meanwhile.
`default_nettype none
`include "fraction_reducer_spf_defines.svh"

module fraction_reducer_spf (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  input  wire logic [1:0]                command_i,
  input  wire logic                      side_i,
  input  wire logic [frs_pkg::VAL_W-1:0] value_i,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  output      logic                      out_side_o,
  output      logic [frs_pkg::VAL_W-1:0] reduced_value_o
);

  localparam int unsigned AW  = frs_pkg::TABLE_AW;
  localparam int unsigned VW  = frs_pkg::VAL_W;
  localparam int unsigned BW  = frs_pkg::BAL_W;
  localparam int unsigned EW  = frs_pkg::EXP_W;
  localparam int unsigned PW  = $clog2(frs_pkg::SIEVE_PMAX + 1);
  localparam int unsigned SW  = BW + 2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK, ST_WAIT, ST_DIV, ST_BRD, ST_BWAIT, ST_MUL, ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    SV_FILL, SV_PINIT, SV_MARK, SV_DONE
  } sieve_e;

  // ---- sieve ----
  sieve_e        sv_q;
  logic [AW:0]   sv_m_q;
  logic [PW-1:0] sv_p_q;
  logic          spf_we;
  logic [AW-1:0] spf_waddr;
  logic [VW-1:0] spf_wdata;
  logic [VW-1:0] spf_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q   <= SV_FILL;
      sv_m_q <= '0;
      sv_p_q <= PW'(frs_pkg::SIEVE_PMAX);
    end else begin
      case (sv_q)
        SV_FILL: begin
          sv_m_q <= sv_m_q + 1'b1;
          if (sv_m_q[AW-1:0] == '1) begin
            sv_q <= SV_PINIT;
          end
        end
        SV_PINIT: begin
          sv_m_q <= (AW+1)'(sv_p_q) * (AW+1)'(sv_p_q);
          sv_q   <= SV_MARK;
        end
        SV_MARK: begin
          if (sv_m_q[AW]) begin
            sv_p_q <= sv_p_q - 1'b1;
            sv_q   <= (sv_p_q == PW'(2)) ? SV_DONE : SV_PINIT;
          end else begin
            sv_m_q <= sv_m_q + (AW+1)'(sv_p_q);
          end
        end
        SV_DONE: sv_q <= SV_DONE;
        default: sv_q <= SV_DONE;
      endcase
    end
  end

  assign spf_we    = (sv_q == SV_FILL) || ((sv_q == SV_MARK) && !sv_m_q[AW]);
  assign spf_waddr = sv_m_q[AW-1:0];
  assign spf_wdata = (sv_q == SV_FILL) ? VW'(sv_m_q[AW-1:0]) : VW'(sv_p_q);

  // ---- balance clearing ----
  logic          clr_busy_q;
  logic [AW-1:0] clr_cnt_q;
  logic          in_acc;
  logic          clr_start;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign clr_start = in_acc && (frs_pkg::command_e'(command_i) == frs_pkg::CMD_CLR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_start) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // ---- item engine ----
  state_e            state_q;
  frs_pkg::command_e cmd_q;
  logic              side_q;
  logic [VW-1:0]     n_q;
  logic [VW-1:0]     p_q;
  logic [EW-1:0]     f_q;
  logic [EW-1:0]     cnt_q;
  logic [VW-1:0]     prod_q;
  logic              out_valid_q;
  logic              out_side_q;
  logic [VW-1:0]     out_val_q;

  frs_pkg::div_req_t div_req;
  logic              div_done;
  logic [VW-1:0]     div_quot;

  logic              bal_we;
  logic [AW-1:0]     bal_waddr;
  logic [BW-1:0]     bal_wdata;
  logic [BW-1:0]     bal_rdata;
  logic [BW-1:0]     bal_new;
  logic [SW-1:0]     bal_ext;
  logic [SW-1:0]     bal_sum;
  logic [SW-1:0]     f_ext;
  logic [SW-1:0]     avail;
  logic [SW-1:0]     cnt_ext;
  logic [EW-1:0]     keep;
  logic              load_out;

  localparam logic [SW-1:0] BAL_MAX = SW'((1 << (BW - 1)) - 1);
  localparam logic [SW-1:0] BAL_MIN = ~BAL_MAX;

  assign bal_ext = {{(SW-BW){bal_rdata[BW-1]}}, bal_rdata};
  assign f_ext   = SW'(f_q);
  assign avail   = side_q ? (SW'(0) - bal_ext) : bal_ext;

  always_comb begin
    keep    = '0;
    bal_sum = '0;
    if (!avail[SW-1] && (avail != '0)) begin
      keep = (avail < f_ext) ? EW'(avail) : f_q;
    end
    cnt_ext = SW'(keep);
    if (cmd_q == frs_pkg::CMD_ACC) begin
      bal_sum = side_q ? (bal_ext - f_ext) : (bal_ext + f_ext);
      if ($signed(bal_sum) > $signed(BAL_MAX)) begin
        bal_sum = BAL_MAX;
      end else if ($signed(bal_sum) < $signed(BAL_MIN)) begin
        bal_sum = BAL_MIN;
      end
    end else begin
      bal_sum = side_q ? (bal_ext + cnt_ext) : (bal_ext - cnt_ext);
    end
    bal_new = bal_sum[BW-1:0];
  end

  assign bal_we    = clr_busy_q || (state_q == ST_BWAIT);
  assign bal_waddr = clr_busy_q ? clr_cnt_q : p_q[AW-1:0];
  assign bal_wdata = clr_busy_q ? '0 : bal_new;

  assign load_out = (state_q == ST_FIN) && (cmd_q == frs_pkg::CMD_RED) &&
                    (!out_valid_q || !out_stall_i);

  assign div_req.start    = (state_q == ST_WAIT) && (n_q > VW'(1)) &&
                            !((f_q != '0) && (spf_rdata != p_q));
  assign div_req.dividend = n_q;
  assign div_req.divisor  = spf_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      f_q         <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          f_q <= '0;
          if (in_acc && ((frs_pkg::command_e'(command_i) == frs_pkg::CMD_ACC) ||
                         (frs_pkg::command_e'(command_i) == frs_pkg::CMD_RED))) begin
            state_q <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (n_q <= VW'(1)) begin
            state_q <= (f_q != '0) ? ST_BRD : ST_FIN;
          end else begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (div_req.start) begin
            f_q     <= f_q + 1'b1;
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_BRD;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_LOOK;
          end
        end
        ST_BRD:   state_q <= ST_BWAIT;
        ST_BWAIT: begin
          f_q     <= '0;
          state_q <= ((cmd_q == frs_pkg::CMD_RED) && (keep != '0)) ? ST_MUL : ST_LOOK;
        end
        ST_MUL: begin
          if (cnt_q == EW'(1)) begin
            state_q <= ST_LOOK;
          end
        end
        ST_FIN: begin
          if ((cmd_q != frs_pkg::CMD_RED) || load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q  <= frs_pkg::command_e'(command_i);
      side_q <= side_i;
      n_q    <= value_i;
      prod_q <= VW'(1);
    end
    if (div_req.start) begin
      p_q <= spf_rdata;
    end
    if ((state_q == ST_DIV) && div_done) begin
      n_q <= div_quot;
    end
    if (state_q == ST_BWAIT) begin
      cnt_q <= keep;
    end
    if (state_q == ST_MUL) begin
      prod_q <= VW'(prod_q * p_q);
      cnt_q  <= cnt_q - 1'b1;
    end
    if (load_out) begin
      out_side_q <= side_q;
      out_val_q  <= prod_q;
    end
  end

  assign in_stall_o      = (state_q != ST_IDLE) || clr_busy_q || (sv_q != SV_DONE);
  assign out_valid_o     = out_valid_q;
  assign out_side_o      = out_side_q;
  assign reduced_value_o = out_val_q;

  frs_ram #(.WIDTH(VW), .DEPTH(frs_pkg::TABLE_SIZE)) u_spf_ram (
    .clk_i   (clk_i),
    .we_i    (spf_we),
    .waddr_i (spf_waddr),
    .wdata_i (spf_wdata),
    .raddr_i (n_q[AW-1:0]),
    .rdata_o (spf_rdata)
  );

  frs_ram #(.WIDTH(BW), .DEPTH(frs_pkg::TABLE_SIZE)) u_bal_ram (
    .clk_i   (clk_i),
    .we_i    (bal_we),
    .waddr_i (bal_waddr),
    .wdata_i (bal_wdata),
    .raddr_i (p_q[AW-1:0]),
    .rdata_o (bal_rdata)
  );

  frs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  `FRS_ASSERT_IMP(a_exp_bound, state_q != ST_IDLE, f_q <= EW'(VW), "exponent count overflow")
  `FRS_ASSERT_IMP(a_clr_idle, clr_busy_q && !clr_start, state_q == ST_IDLE, "clear during item")
  `FRS_ASSERT_IMP(a_out_free, load_out, !out_valid_q || !out_stall_i, "output overwritten")
  `FRS_ASSERT_NXT(a_div_lat, div_req.start, state_q == ST_DIV && !div_done, "divider start lost")

endmodule

`default_nettype wire
